@@ hdl/altok_pkg.sv @@
`default_nettype none

package altok_pkg;

  localparam int MAX_CMD_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_UC_W  = 8'h57;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [1:0] SZ_B = 2'd0;
  localparam logic [1:0] SZ_C = 2'd1;
  localparam logic [1:0] SZ_W = 2'd2;
  localparam logic [1:0] SZ_D = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_COMMENT = 2'd1;
  localparam logic [1:0] ST_NOCMD   = 2'd2;

  typedef enum logic [3:0] {
    CLS_BLANK,
    CLS_SPACE,
    CLS_QUOTE,
    CLS_LETTER,
    CLS_AMP,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_CMD,
    PH_PREAMP,
    PH_PRESIZE,
    PH_ARGWS,
    PH_DIGITS,
    PH_DONE,
    PH_COMMENT,
    PH_NOCMD
  } phase_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    cls_t       cls;
    logic       size_hit;
    logic [1:0] size_val;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic letter;
    logic amp;
    logic size;
    logic neg;
    logic digit;
  } act_t;

endpackage

`default_nettype wire

@@ hdl/altok_ifs.sv @@
`default_nettype none

interface altok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface altok_out_if;
  logic               valid;
  logic               ready;
  logic        [63:0] command_text;
  logic        [3:0]  command_length;
  logic               command_truncated;
  logic               pointer_mark;
  logic        [1:0]  size_code;
  logic signed [31:0] argument;
  logic        [1:0]  status;

  modport source (output valid, output command_text, output command_length,
                  output command_truncated, output pointer_mark, output size_code,
                  output argument, output status, input ready);
  modport sink   (input valid, input command_text, input command_length,
                  input command_truncated, input pointer_mark, input size_code,
                  input argument, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/asm_line_tokenizer_unit.sv @@
// Line tokenizer: one character per request, one result per line (on the last character).
// Throughput: one character per cycle, set by the scan step; a last character stalls while an
// earlier result is still in the output register and not taken. The result is registered: the
// last character goes into the queue; the scan stage then pops it into the output register.
// Reset (rst, synchronous): queue emptied, scan state cleared, output invalid.
`default_nettype none

module asm_line_tokenizer_unit #(
  parameter int MAX_CMD     = altok_pkg::MAX_CMD_DEF,
  parameter int QUEUE_DEPTH = altok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  altok_in_if.sink    line_in,
  altok_out_if.source token_out
);
  import altok_pkg::*;

  q_stat_t qs;
  tok_t    tok_in;
  tok_t    tok_out;
  logic    push;
  logic    pop;

  altok_front u_front (
    .line_in (line_in),
    .qs      (qs),
    .push    (push),
    .tok     (tok_in)
  );

  altok_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (tok_in),
    .pop  (pop),
    .dout (tok_out),
    .qs   (qs)
  );

  altok_back #(
    .MAX_CMD (MAX_CMD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .tok       (tok_out),
    .pop       (pop),
    .token_out (token_out)
  );

`ifndef SYNTHESIS
  a_err_fields_zero : assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.status != ST_OK) |->
      (token_out.command_length == 4'd0 && token_out.argument == 32'sd0 &&
       token_out.command_text == 64'd0))
    else $error("non-ok line carries nonzero fields");

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    token_out.valid |-> (token_out.command_length <= 4'(MAX_CMD)))
    else $error("command length beyond limit");

  a_trunc_full : assert property (@(posedge clk) disable iff (rst)
    (token_out.valid && token_out.command_truncated) |->
      (token_out.command_length == 4'(MAX_CMD)))
    else $error("truncation flagged with buffer not full");

  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    qs.empty |-> !pop)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ hdl/altok_front.sv @@
`default_nettype none

module altok_front (
  altok_in_if.sink         line_in,
  input  altok_pkg::q_stat_t qs,
  output logic             push,
  output altok_pkg::tok_t  tok
);
  import altok_pkg::*;

  logic [7:0] upper;

  assign line_in.ready = !qs.full;
  assign push          = line_in.valid && !qs.full;

  assign upper = (line_in.ch inside {[CH_LC_A:CH_LC_Z]}) ? (line_in.ch & ~CASE_BIT)
                                                          : line_in.ch;

  always_comb begin
    tok.ch   = line_in.ch;
    tok.last = line_in.last;

    if (line_in.ch == CH_SPACE || line_in.ch == CH_TAB) begin
      tok.cls = CLS_BLANK;
    end else if (line_in.ch inside {[CH_LF:CH_CR]}) begin
      tok.cls = CLS_SPACE;
    end else if (line_in.ch == CH_QUOTE) begin
      tok.cls = CLS_QUOTE;
    end else if (line_in.ch inside {[CH_UC_A:CH_UC_Z], [CH_LC_A:CH_LC_Z]}) begin
      tok.cls = CLS_LETTER;
    end else if (line_in.ch == CH_AMP) begin
      tok.cls = CLS_AMP;
    end else if (line_in.ch == CH_PLUS) begin
      tok.cls = CLS_PLUS;
    end else if (line_in.ch == CH_MINUS) begin
      tok.cls = CLS_MINUS;
    end else if (line_in.ch inside {[CH_ZERO:CH_NINE]}) begin
      tok.cls = CLS_DIGIT;
    end else begin
      tok.cls = CLS_OTHER;
    end

    case (upper)
      CH_UC_B: begin tok.size_hit = 1'b1; tok.size_val = SZ_B; end
      CH_UC_C: begin tok.size_hit = 1'b1; tok.size_val = SZ_C; end
      CH_UC_W: begin tok.size_hit = 1'b1; tok.size_val = SZ_W; end
      CH_UC_D: begin tok.size_hit = 1'b1; tok.size_val = SZ_D; end
      default: begin tok.size_hit = 1'b0; tok.size_val = SZ_B; end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/altok_fifo.sv @@
`default_nettype none

module altok_fifo #(
  parameter int DEPTH = altok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  altok_pkg::tok_t    din,
  input  logic               pop,
  output altok_pkg::tok_t    dout,
  output altok_pkg::q_stat_t qs
);
  import altok_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign qs.full  = (count == CW'(DEPTH));
  assign qs.empty = (count == '0);
  assign dout     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/altok_back.sv @@
`default_nettype none

module altok_back #(
  parameter int MAX_CMD = altok_pkg::MAX_CMD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  altok_pkg::q_stat_t qs,
  input  altok_pkg::tok_t    tok,
  output logic               pop,
  altok_out_if.source        token_out
);
  import altok_pkg::*;

  phase_t      phase, phase_next;
  act_t        act;
  logic [63:0] cmd_buf, cmd_buf_next;
  logic [3:0]  kept, kept_next;
  logic        ovf, ovf_next;
  logic        amp, amp_next;
  logic [1:0]  size, size_next;
  logic        neg, neg_next;
  logic [31:0] acc, acc_next;

  logic        out_valid;
  logic        out_free;
  logic        emit;
  logic        line_ok;
  logic [63:0] o_text;
  logic [3:0]  o_len;
  logic        o_trunc;
  logic        o_amp;
  logic [1:0]  o_size;
  logic        o_neg;
  logic [31:0] o_acc;
  logic [1:0]  o_status;

  // scan step, following the fall-through order of the line grammar
  always_comb begin
    phase_t p;
    logic   taken;
    p     = phase;
    taken = 1'b0;
    act   = '0;
    if (p == PH_LEAD) begin
      if (tok.cls == CLS_QUOTE) begin
        p = PH_COMMENT;
      end else if (tok.cls == CLS_LETTER) begin
        act.letter = 1'b1;
        p          = PH_CMD;
      end else if (tok.cls != CLS_BLANK) begin
        p = PH_NOCMD;
      end
    end else begin
      if (p == PH_CMD) begin
        if (tok.cls == CLS_LETTER) begin
          act.letter = 1'b1;
          taken      = 1'b1;
        end else begin
          p = PH_PREAMP;
        end
      end
      if (p == PH_PREAMP && !taken) begin
        if (tok.cls == CLS_BLANK) begin
          taken = 1'b1;
        end else begin
          p = PH_PRESIZE;
          if (tok.cls == CLS_AMP) begin
            act.amp = 1'b1;
            taken   = 1'b1;
          end
        end
      end
      if (p == PH_PRESIZE && !taken) begin
        if (tok.cls == CLS_BLANK) begin
          taken = 1'b1;
        end else begin
          p = PH_ARGWS;
          if (tok.size_hit) begin
            act.size = 1'b1;
            taken    = 1'b1;
          end
        end
      end
      if (p == PH_ARGWS && !taken) begin
        if (tok.cls == CLS_BLANK || tok.cls == CLS_SPACE) begin
          taken = 1'b1;
        end else if (tok.cls == CLS_PLUS) begin
          p     = PH_DIGITS;
          taken = 1'b1;
        end else if (tok.cls == CLS_MINUS) begin
          act.neg = 1'b1;
          p       = PH_DIGITS;
          taken   = 1'b1;
        end else if (tok.cls != CLS_DIGIT) begin
          p     = PH_DONE;
          taken = 1'b1;
        end else begin
          p = PH_DIGITS;
        end
      end
      if (p == PH_DIGITS && !taken) begin
        if (tok.cls == CLS_DIGIT) begin
          act.digit = 1'b1;
        end else begin
          p = PH_DONE;
        end
      end
    end
    phase_next = p;
  end

  // handshake control
  always_comb begin
    out_free = !out_valid || token_out.ready;
    pop      = !qs.empty && (!tok.last || out_free);
    emit     = pop && tok.last;
  end

  always_comb begin
    cmd_buf_next = cmd_buf;
    kept_next    = kept;
    ovf_next     = ovf;
    if (act.letter) begin
      if (kept < 4'(MAX_CMD)) begin
        cmd_buf_next = cmd_buf | ({56'b0, tok.ch} << {kept[2:0], 3'b000});
        kept_next    = kept + 1'b1;
      end else begin
        ovf_next = 1'b1;
      end
    end
    amp_next  = act.amp ? 1'b1 : amp;
    size_next = act.size ? tok.size_val : size;
    neg_next  = act.neg ? 1'b1 : neg;
    acc_next  = act.digit ? ({acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'b0, tok.ch[3:0]})
                          : acc;
    line_ok   = !(phase_next == PH_COMMENT || phase_next == PH_LEAD ||
                  phase_next == PH_NOCMD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_LEAD;
      cmd_buf <= '0;
      kept    <= '0;
      ovf     <= 1'b0;
      amp     <= 1'b0;
      size    <= SZ_B;
      neg     <= 1'b0;
      acc     <= '0;
    end else if (pop) begin
      if (tok.last) begin
        phase   <= PH_LEAD;
        cmd_buf <= '0;
        kept    <= '0;
        ovf     <= 1'b0;
        amp     <= 1'b0;
        size    <= SZ_B;
        neg     <= 1'b0;
        acc     <= '0;
      end else begin
        phase   <= phase_next;
        cmd_buf <= cmd_buf_next;
        kept    <= kept_next;
        ovf     <= ovf_next;
        amp     <= amp_next;
        size    <= size_next;
        neg     <= neg_next;
        acc     <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (token_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_text  <= line_ok ? cmd_buf_next : '0;
      o_len   <= line_ok ? kept_next : '0;
      o_trunc <= line_ok && ovf_next;
      o_amp   <= line_ok && amp_next;
      o_size  <= line_ok ? size_next : SZ_B;
      o_neg   <= line_ok && neg_next;
      o_acc   <= line_ok ? acc_next : '0;
      if (phase_next == PH_COMMENT) begin
        o_status <= ST_COMMENT;
      end else if (line_ok) begin
        o_status <= ST_OK;
      end else begin
        o_status <= ST_NOCMD;
      end
    end
  end

  // sign applied after the register
  assign token_out.valid             = out_valid;
  assign token_out.command_text      = o_text;
  assign token_out.command_length    = o_len;
  assign token_out.command_truncated = o_trunc;
  assign token_out.pointer_mark      = o_amp;
  assign token_out.size_code         = o_size;
  assign token_out.argument          = o_neg ? -o_acc : o_acc;
  assign token_out.status            = o_status;

endmodule

`default_nettype wire
